// ----- design/assert_macros.svh -----
// Assertion macros for the decoder RTL; included by the top level.
// Defining NO_ASSERTIONS turns every macro into an empty statement.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every rising edge outside of reset.
`define CSAD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("csad check failed");

// Condition must never be true outside of reset.
`define CSAD_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("csad forbidden condition seen");

`else

`define CSAD_ASSERT(lbl, clk, rst_n, prop)
`define CSAD_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ----- design/csad_pkg.sv -----
// Types and constants of the chip-select address decoder.
// Used by every module of the decoder; depends on nothing.
package csad_pkg;

    // Target codes of a decoded access.
    localparam logic [2:0] TGT_NONE   = 3'd0;
    localparam logic [2:0] TGT_REGS   = 3'd1;
    localparam logic [2:0] TGT_ROM    = 3'd2;
    localparam logic [2:0] TGT_SEDREG = 3'd3;
    localparam logic [2:0] TGT_FB     = 3'd4;
    localparam logic [2:0] TGT_USB    = 3'd5;
    localparam logic [2:0] TGT_RAM    = 3'd6;

    // Access size codes.
    localparam logic [1:0] SZ_BYTE     = 2'd0;
    localparam logic [1:0] SZ_WORD     = 2'd1;
    localparam logic [1:0] SZ_LONG     = 2'd2;
    localparam logic [1:0] SZ_LONG_PRE = 2'd3;

    // Configuration register indexes (byte address is 8 times the index).
    localparam logic [2:0] IDX_ROM_WINDOW = 3'd0;
    localparam logic [2:0] IDX_ROM_ATTR   = 3'd1;
    localparam logic [2:0] IDX_SED_WINDOW = 3'd2;
    localparam logic [2:0] IDX_SED_ATTR   = 3'd3;
    localparam logic [2:0] IDX_USB_WINDOW = 3'd4;
    localparam logic [2:0] IDX_USB_ATTR   = 3'd5;
    localparam logic [2:0] IDX_RAM_WINDOW = 3'd6;
    localparam logic [2:0] IDX_RAM_ATTR   = 3'd7;

    // Attribute bit positions.
    localparam int ATTR_RO      = 32;
    localparam int ATTR_SUPER   = 33;
    localparam int ATTR_RO_PROT = 34;
    localparam int ATTR_ENABLE  = 35;
    localparam int ATTR_BOOT    = 36;  // rom_attr
    localparam int ATTR_MIRROR  = 37;  // rom_attr
    localparam int ATTR_ATTACH  = 36;  // sed_attr
    localparam int ATTR_PSAVE   = 37;  // sed_attr

    localparam logic [37:0] ROM_ATTR_RESET  = 38'h10_0000_0000;
    localparam logic [31:0] MIRROR_PATTERN = 32'h00FF_F000;

    typedef struct packed {
        logic [63:0] rom_window;
        logic [37:0] rom_attr;
        logic [63:0] sed_window;
        logic [37:0] sed_attr;
        logic [63:0] usb_window;
        logic [35:0] usb_attr;
        logic [63:0] ram_window;
        logic [35:0] ram_attr;
    } t_cfg;

    typedef struct packed {
        logic        req_type;
        logic [31:0] address;
        logic [1:0]  access_size;
        logic        supervisor;
        logic [31:0] write_data;
    } t_req;

    typedef struct packed {
        logic [2:0]  target;
        logic [31:0] local_offset;
        logic [31:0] data_out;
        logic [1:0]  size_out;
        logic        forward_access;
        logic        read_zero;
        logic        privilege_fault;
        logic        write_protect_fault;
        logic        bus_error;
    } t_rsp;

endpackage

// ----- design/csad_cfg_regs.sv -----
// Configuration register file of the decoder with its APB-style port.
// Depends on csad_pkg for the register indexes and the t_cfg struct.
module csad_cfg_regs
    import csad_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rom_window <= '0;
            r_cfg.rom_attr   <= ROM_ATTR_RESET;
            r_cfg.sed_window <= '0;
            r_cfg.sed_attr   <= '0;
            r_cfg.usb_window <= '0;
            r_cfg.usb_attr   <= '0;
            r_cfg.ram_window <= '0;
            r_cfg.ram_attr   <= '0;
        end else if (wr_en) begin
            case (idx)
                IDX_ROM_WINDOW: r_cfg.rom_window <= pwdata;
                IDX_ROM_ATTR:   r_cfg.rom_attr   <= pwdata[37:0];
                IDX_SED_WINDOW: r_cfg.sed_window <= pwdata;
                IDX_SED_ATTR:   r_cfg.sed_attr   <= pwdata[37:0];
                IDX_USB_WINDOW: r_cfg.usb_window <= pwdata;
                IDX_USB_ATTR:   r_cfg.usb_attr   <= pwdata[35:0];
                IDX_RAM_WINDOW: r_cfg.ram_window <= pwdata;
                IDX_RAM_ATTR:   r_cfg.ram_attr   <= pwdata[35:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            IDX_ROM_WINDOW: prdata = r_cfg.rom_window;
            IDX_ROM_ATTR:   prdata = {26'b0, r_cfg.rom_attr};
            IDX_SED_WINDOW: prdata = r_cfg.sed_window;
            IDX_SED_ATTR:   prdata = {26'b0, r_cfg.sed_attr};
            IDX_USB_WINDOW: prdata = r_cfg.usb_window;
            IDX_USB_ATTR:   prdata = {28'b0, r_cfg.usb_attr};
            IDX_RAM_WINDOW: prdata = r_cfg.ram_window;
            IDX_RAM_ATTR:   prdata = {28'b0, r_cfg.ram_attr};
            default:        prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ----- design/csad_win_match.sv -----
// Window matcher: bank-granular hit test and masked offset for one chip window.
// Depends on csad_pkg only through the common import convention.
module csad_win_match
    import csad_pkg::*;
#(
    parameter int unsigned BANK_SHIFT = 14
) (
    input  logic [31:0] i_addr,
    input  logic [63:0] i_window,
    input  logic        i_enable,
    output logic        o_hit,
    output logic [31:0] o_offset
);

    logic [31:0] base;
    logic [31:0] size;
    logic [32:0] last_addr;
    logic        above_first;
    logic        below_last;

    assign base = i_window[31:0];
    assign size = i_window[63:32];

    // The window end is not wrapped, so it may run past the 4 GiB boundary.
    assign last_addr   = {1'b0, base} + {1'b0, size} - 33'd1;
    assign above_first = i_addr[31:BANK_SHIFT] >= base[31:BANK_SHIFT];
    assign below_last  = {1'b0, i_addr[31:BANK_SHIFT]} <= last_addr[32:BANK_SHIFT];

    assign o_hit    = i_enable && (size != 32'd0) && above_first && below_last;
    assign o_offset = (i_addr - base) & (size - 32'd1);

endmodule

// ----- design/csad_decode.sv -----
// Decode logic: target priority, local offset, protection checks and flags.
// Depends on csad_pkg and instantiates csad_win_match for each chip window.
module csad_decode
    import csad_pkg::*;
#(
    parameter int unsigned BANK_SHIFT = 14,
    parameter logic [31:0] REG_BASE   = 32'hFFFF_F000,
    parameter logic [31:0] REG_BYTES  = 32'h0000_1000,
    parameter logic [31:0] FB_OFFSET  = 32'h0002_0000
) (
    input  t_req i_req,
    input  t_cfg i_cfg,
    output t_rsp o_rsp
);

    localparam logic [32:0] REG_LAST = {1'b0, REG_BASE} + {1'b0, REG_BYTES} - 33'd1;

    logic        wr;
    logic [31:0] addr;
    logic        rom_hit, sed_hit, usb_hit, ram_hit;
    logic [31:0] rom_off, sed_off, usb_off, ram_off;
    logic        mirror_hit, reg_hit;
    logic [2:0]  target;
    logic [31:0] loc;
    logic [31:0] prot_off;
    logic [35:0] attr;
    logic        checked;
    logic        above;
    logic        priv, wp, fwd, rz, berr;

    assign wr   = i_req.req_type;
    assign addr = i_req.address;

    csad_win_match #(.BANK_SHIFT(BANK_SHIFT)) u_rom (
        .i_addr(addr), .i_window(i_cfg.rom_window),
        .i_enable(i_cfg.rom_attr[ATTR_ENABLE]), .o_hit(rom_hit), .o_offset(rom_off)
    );
    csad_win_match #(.BANK_SHIFT(BANK_SHIFT)) u_sed (
        .i_addr(addr), .i_window(i_cfg.sed_window),
        .i_enable(i_cfg.sed_attr[ATTR_ENABLE] && i_cfg.sed_attr[ATTR_ATTACH]),
        .o_hit(sed_hit), .o_offset(sed_off)
    );
    csad_win_match #(.BANK_SHIFT(BANK_SHIFT)) u_usb (
        .i_addr(addr), .i_window(i_cfg.usb_window),
        .i_enable(i_cfg.usb_attr[ATTR_ENABLE]), .o_hit(usb_hit), .o_offset(usb_off)
    );
    csad_win_match #(.BANK_SHIFT(BANK_SHIFT)) u_ram (
        .i_addr(addr), .i_window(i_cfg.ram_window),
        .i_enable(i_cfg.ram_attr[ATTR_ENABLE]), .o_hit(ram_hit), .o_offset(ram_off)
    );

    // The register banks are mirrored at one bank of every 16 MiB in mirror mode.
    assign mirror_hit = i_cfg.rom_attr[ATTR_MIRROR]
                     && (addr[23:BANK_SHIFT] == MIRROR_PATTERN[23:BANK_SHIFT]);
    assign reg_hit    = (addr[31:BANK_SHIFT] >= REG_BASE[31:BANK_SHIFT])
                     && ({1'b0, addr[31:BANK_SHIFT]} <= REG_LAST[32:BANK_SHIFT]);

    always_comb begin
        target   = TGT_NONE;
        loc      = '0;
        prot_off = '0;
        attr     = '0;
        checked  = 1'b0;
        if (mirror_hit || reg_hit) begin
            target = TGT_REGS;
            // REG_BYTES is a power of two, so the modulo is a mask.
            loc    = addr & (REG_BYTES - 32'd1);
        end else if (i_cfg.rom_attr[ATTR_BOOT] || rom_hit) begin
            target   = TGT_ROM;
            attr     = i_cfg.rom_attr[35:0];
            checked  = 1'b1;
            prot_off = rom_off;
            loc      = rom_off;
        end else if (sed_hit) begin
            attr     = i_cfg.sed_attr[35:0];
            checked  = 1'b1;
            prot_off = sed_off;
            if (sed_off < FB_OFFSET) begin
                target = TGT_SEDREG;
                loc    = {24'b0, sed_off[7:0]};
            end else begin
                target = TGT_FB;
                loc    = sed_off - FB_OFFSET;
            end
        end else if (usb_hit) begin
            target   = TGT_USB;
            attr     = i_cfg.usb_attr;
            checked  = 1'b1;
            prot_off = usb_off;
            loc      = usb_off;
        end else if (ram_hit) begin
            target   = TGT_RAM;
            attr     = i_cfg.ram_attr;
            checked  = 1'b1;
            prot_off = ram_off;
            loc      = ram_off;
        end
    end

    assign above = prot_off >= attr[31:0];

    always_comb begin
        priv = 1'b0;
        wp   = 1'b0;
        if (checked) begin
            if (!wr) begin
                priv = attr[ATTR_SUPER] && above && !i_req.supervisor;
            end else if (attr[ATTR_RO]) begin
                wp = 1'b1;
            end else if (above) begin
                if (attr[ATTR_SUPER] && !i_req.supervisor) begin
                    priv = 1'b1;
                end else begin
                    wp = attr[ATTR_RO_PROT];
                end
            end
        end
    end

    always_comb begin
        fwd  = 1'b0;
        rz   = 1'b0;
        berr = 1'b0;
        if (target == TGT_NONE) begin
            berr = 1'b1;
            rz   = !wr;
        end else if (priv || wp || target == TGT_USB) begin
            rz = !wr;
        end else if (target == TGT_ROM) begin
            fwd = !wr;
        end else if ((target == TGT_SEDREG || target == TGT_FB) && !wr
                     && i_cfg.sed_attr[ATTR_PSAVE]) begin
            rz = 1'b1;
        end else begin
            fwd = 1'b1;
        end
    end

    always_comb begin
        o_rsp.target       = target;
        o_rsp.local_offset = loc;
        if (!wr) begin
            o_rsp.data_out = '0;
        end else if (i_req.access_size == SZ_LONG_PRE) begin
            o_rsp.data_out = {i_req.write_data[15:0], i_req.write_data[31:16]};
        end else begin
            o_rsp.data_out = i_req.write_data;
        end
        o_rsp.size_out            = (i_req.access_size == SZ_LONG_PRE) ? SZ_LONG
                                                                       : i_req.access_size;
        o_rsp.forward_access      = fwd;
        o_rsp.read_zero           = rz;
        o_rsp.privilege_fault     = priv;
        o_rsp.write_protect_fault = wp;
        o_rsp.bus_error           = berr;
    end

endmodule

// ----- design/chip_select_address_decoder.sv -----
// Top level of the chip-select address decoder: stream ports, input and result
// registers. Depends on csad_pkg, csad_cfg_regs, csad_decode and assert_macros.svh.
//
// Usage: each bus access enters as one transaction on the s_axis channel and
// leaves as one decoded transaction on the m_axis channel, in order. The
// decode covers the target chip, the offset inside it, the data to pass on,
// and the privilege, write protection and bus error flags.
// The result is registered: an accepted transaction enters the input register, then the
// result register once that is empty or drains. Throughput is one transaction per cycle
// while the receiver does not stall: an input register feeds one level of decode logic,
// whose window compares and offset subtracts set the cycle time, into a result register.
// The APB port writes the window and attribute registers; the user must write them only
// while no transaction is in flight, as the block does not enforce it. pready is always high.
// Reset (synchronous, active low) empties both pipeline registers and loads
// the register defaults: everything zero except ROM boot mode on.
// When the receiver stalls, the result register holds its transaction and the
// input register still takes one more transaction before s_axis_tready falls.
`include "assert_macros.svh"

module chip_select_address_decoder
    import csad_pkg::*;
#(
    parameter int unsigned BANK_SHIFT = 14,
    parameter logic [31:0] REG_BASE   = 32'hFFFF_F000,
    parameter logic [31:0] REG_BYTES  = 32'h0000_1000,
    parameter logic [31:0] FB_OFFSET  = 32'h0002_0000
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // address[31:0], access_size[33:32], supervisor[34], write_data[66:35], zero pad
    input  logic [71:0] s_axis_tdata,
    // req_type[0]
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // local_offset[31:0], data_out[63:32], size_out[65:64], forward_access[66],
    // read_zero[67], privilege_fault[68], write_protect_fault[69], bus_error[70], pad
    output logic [71:0] m_axis_tdata,
    // target[2:0]
    output logic [2:0]  m_axis_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    t_cfg cfg;
    t_req r_req;
    t_req n_req;
    t_rsp r_rsp;
    t_rsp n_rsp;
    logic r_req_vld;
    logic n_req_vld;
    logic r_rsp_vld;
    logic n_rsp_vld;
    logic in_take;
    logic advance;

    csad_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    csad_decode #(
        .BANK_SHIFT (BANK_SHIFT),
        .REG_BASE   (REG_BASE),
        .REG_BYTES  (REG_BYTES),
        .FB_OFFSET  (FB_OFFSET)
    ) u_decode (
        .i_req (r_req),
        .i_cfg (cfg),
        .o_rsp (n_rsp)
    );

    // The decoded transaction moves on when the result register is empty or drains.
    assign advance       = r_req_vld && (!r_rsp_vld || m_axis_tready);
    assign s_axis_tready = !r_req_vld || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_req.req_type    = s_axis_tuser[0];
        n_req.address     = s_axis_tdata[31:0];
        n_req.access_size = s_axis_tdata[33:32];
        n_req.supervisor  = s_axis_tdata[34];
        n_req.write_data  = s_axis_tdata[66:35];
        n_req_vld = in_take ? 1'b1 : (advance ? 1'b0 : r_req_vld);
        n_rsp_vld = advance ? 1'b1 : (m_axis_tready ? 1'b0 : r_rsp_vld);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
            r_rsp_vld <= 1'b0;
        end else begin
            r_req_vld <= n_req_vld;
            r_rsp_vld <= n_rsp_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_req <= n_req;
        end
        if (advance) begin
            r_rsp <= n_rsp;
        end
    end

    assign m_axis_tvalid = r_rsp_vld;
    assign m_axis_tuser  = r_rsp.target;
    assign m_axis_tdata  = {1'b0, r_rsp.bus_error, r_rsp.write_protect_fault,
                            r_rsp.privilege_fault, r_rsp.read_zero, r_rsp.forward_access,
                            r_rsp.size_out, r_rsp.data_out, r_rsp.local_offset};

    // An accepted transaction always lands in the input register.
    `CSAD_ASSERT(a_take_loads, i_clk, i_rst_n, (s_axis_tvalid && s_axis_tready) |=> r_req_vld)
    // A result only appears after a decoded transaction moved forward.
    `CSAD_ASSERT(a_rsp_source, i_clk, i_rst_n, $rose(r_rsp_vld) |-> $past(advance))
    // A faulting or unmapped access is never passed on to a chip.
    `CSAD_NEVER(a_fault_no_fwd, i_clk, i_rst_n, r_rsp_vld && r_rsp.forward_access && (r_rsp.privilege_fault || r_rsp.write_protect_fault || r_rsp.bus_error))

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking bench for chip_select_address_decoder: directed and random bus accesses
// on the stream input, decoded results compared with a behavioral decode in the bench.
// Depends on csad_pkg and the decoder RTL only.

module testbench;
    import csad_pkg::*;

    localparam int unsigned BANK_SHIFT    = 14;
    localparam logic [31:0] REG_BASE      = 32'hFFFF_F000;
    localparam logic [31:0] REG_BYTES     = 32'h0000_1000;
    localparam logic [31:0] FB_OFFSET     = 32'h0002_0000;
    localparam logic [31:0] DISP_REG_MASK = 32'h0000_00FF;
    localparam logic        REQ_READ      = 1'b0;
    localparam logic        REQ_WRITE     = 1'b1;
    localparam int          PHASES        = 12;
    localparam int          ACCESSES_PER_PHASE = 120;
    localparam int          STALL_STRETCH = 60;

    typedef enum logic [1:0] {ROW_CONFIG, ROW_PREDICT, ROW_KNOWN} t_row_kind;

    typedef struct {
        t_row_kind kind;
        t_cfg      cfg;
        t_req      req;
        t_rsp      rsp;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;   // address, access_size, supervisor, write_data, pad
    logic [0:0]  s_axis_tuser;   // req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;   // local_offset, data_out, size_out, flags, pad
    logic [2:0]  m_axis_tuser;   // target
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    t_cfg chip_map;
    t_rsp decodes_in_flight[$];
    int   mismatches = 0;
    int   sender_gap_pct = 0;
    int   receiver_stall_pct = 0;
    int   stall_left = 0;
    logic stall_request = 1'b0;

    chip_select_address_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Windows are matched per bank; the end of a window is not wrapped at 4 GiB.
    function automatic logic bank_match(input logic [31:0] addr, input logic [31:0] base,
                                        input logic [31:0] size);
        logic [32:0] last_byte;
        if (size == '0)
            return 1'b0;
        last_byte = {1'b0, base} + {1'b0, size} - 33'd1;
        return ({1'b0, addr} >> BANK_SHIFT) >= ({1'b0, base} >> BANK_SHIFT) &&
               ({1'b0, addr} >> BANK_SHIFT) <= (last_byte >> BANK_SHIFT);
    endfunction

    function automatic logic [31:0] window_offset(input logic [31:0] addr,
                                                  input logic [63:0] win);
        return (addr - win[31:0]) & (win[63:32] - 32'd1);
    endfunction

    function automatic t_rsp decode_access(input t_req r, input t_cfg c);
        t_rsp        o;
        logic [37:0] attr;
        logic [31:0] poff;
        logic        checked;
        o = '0;
        attr = '0;
        poff = '0;
        checked = 1'b0;
        if (c.rom_attr[ATTR_MIRROR] &&
            r.address[23:BANK_SHIFT] == MIRROR_PATTERN[23:BANK_SHIFT]) begin
            o.target = TGT_REGS;
        end else if (bank_match(r.address, REG_BASE, REG_BYTES)) begin
            o.target = TGT_REGS;
        end else if (c.rom_attr[ATTR_BOOT] || (c.rom_attr[ATTR_ENABLE] &&
                     bank_match(r.address, c.rom_window[31:0], c.rom_window[63:32]))) begin
            o.target = TGT_ROM;
            attr = c.rom_attr;
            checked = 1'b1;
            poff = window_offset(r.address, c.rom_window);
            o.local_offset = poff;
        end else if (c.sed_attr[ATTR_ATTACH] && c.sed_attr[ATTR_ENABLE] &&
                     bank_match(r.address, c.sed_window[31:0], c.sed_window[63:32])) begin
            attr = c.sed_attr;
            checked = 1'b1;
            poff = window_offset(r.address, c.sed_window);
            if (poff < FB_OFFSET) begin
                o.target = TGT_SEDREG;
                o.local_offset = poff & DISP_REG_MASK;
            end else begin
                o.target = TGT_FB;
                o.local_offset = poff - FB_OFFSET;
            end
        end else if (c.usb_attr[ATTR_ENABLE] &&
                     bank_match(r.address, c.usb_window[31:0], c.usb_window[63:32])) begin
            o.target = TGT_USB;
            attr = 38'(c.usb_attr);
            checked = 1'b1;
            poff = window_offset(r.address, c.usb_window);
            o.local_offset = poff;
        end else if (c.ram_attr[ATTR_ENABLE] &&
                     bank_match(r.address, c.ram_window[31:0], c.ram_window[63:32])) begin
            o.target = TGT_RAM;
            attr = 38'(c.ram_attr);
            checked = 1'b1;
            poff = window_offset(r.address, c.ram_window);
            o.local_offset = poff;
        end
        if (o.target == TGT_REGS)
            o.local_offset = r.address % REG_BYTES;

        // Protection is judged on the offset inside the window.
        if (checked) begin
            if (r.req_type == REQ_READ) begin
                o.privilege_fault = attr[ATTR_SUPER] && poff >= attr[31:0] && !r.supervisor;
            end else if (attr[ATTR_RO]) begin
                o.write_protect_fault = 1'b1;
            end else if (poff >= attr[31:0]) begin
                if (attr[ATTR_SUPER] && !r.supervisor)
                    o.privilege_fault = 1'b1;
                else if (attr[ATTR_RO_PROT])
                    o.write_protect_fault = 1'b1;
            end
        end

        if (r.req_type == REQ_WRITE)
            o.data_out = (r.access_size == SZ_LONG_PRE) ?
                         {r.write_data[15:0], r.write_data[31:16]} : r.write_data;
        o.size_out = (r.access_size == SZ_LONG_PRE) ? SZ_LONG : r.access_size;

        if (o.target == TGT_NONE) begin
            o.bus_error = 1'b1;
            o.read_zero = (r.req_type == REQ_READ);
        end else if (o.privilege_fault || o.write_protect_fault || o.target == TGT_USB) begin
            o.read_zero = (r.req_type == REQ_READ);
        end else if (o.target == TGT_ROM) begin
            o.forward_access = (r.req_type == REQ_READ);
        end else if ((o.target == TGT_SEDREG || o.target == TGT_FB) &&
                     r.req_type == REQ_READ && c.sed_attr[ATTR_PSAVE]) begin
            o.read_zero = 1'b1;
        end else begin
            o.forward_access = 1'b1;
        end
        return o;
    endfunction

    function automatic t_req mk_req(input logic wr, input logic [31:0] addr,
                                    input logic [1:0] size, input logic sup,
                                    input logic [31:0] wdata);
        t_req r;
        r.req_type = wr;
        r.address = addr;
        r.access_size = size;
        r.supervisor = sup;
        r.write_data = wdata;
        return r;
    endfunction

    // Flags are given as {forward, read_zero, privilege, write_protect, bus_error}.
    function automatic t_rsp mk_rsp(input logic [2:0] tgt, input logic [31:0] offset,
                                    input logic [31:0] dout, input logic [1:0] size,
                                    input logic [4:0] flags);
        t_rsp o;
        o.target = tgt;
        o.local_offset = offset;
        o.data_out = dout;
        o.size_out = size;
        {o.forward_access, o.read_zero, o.privilege_fault, o.write_protect_fault,
         o.bus_error} = flags;
        return o;
    endfunction

    function automatic logic [63:0] random_window();
        logic [31:0] base;
        logic [31:0] size;
        base = $urandom;
        if ($urandom_range(1))
            base[13:0] = '0;
        case ($urandom_range(5))
            0: size = '0;
            1: size = $urandom;
            2: size = ~base + 32'd1 + 32'($urandom_range(32'hFFFF));
            default: size = 32'd1 << $urandom_range(20, 12);
        endcase
        return {size, base};
    endfunction

    function automatic logic [31:0] random_unprotected(input logic [31:0] size);
        case ($urandom_range(3))
            0: return '0;
            1: return $urandom;
            default: return 32'(64'($urandom) % (64'(size) + 64'd1));
        endcase
    endfunction

    function automatic t_cfg random_config();
        t_cfg c;
        c.rom_window = random_window();
        c.sed_window = random_window();
        c.usb_window = random_window();
        c.ram_window = random_window();
        c.rom_attr = {1'($urandom_range(1)), ($urandom_range(3) == 0),
                      ($urandom_range(7) != 0), 3'($urandom),
                      random_unprotected(c.rom_window[63:32])};
        c.sed_attr = {($urandom_range(3) == 0), ($urandom_range(3) != 0),
                      ($urandom_range(7) != 0), 3'($urandom),
                      random_unprotected(c.sed_window[63:32])};
        c.usb_attr = {($urandom_range(7) != 0), 3'($urandom),
                      random_unprotected(c.usb_window[63:32])};
        c.ram_attr = {($urandom_range(7) != 0), 3'($urandom),
                      random_unprotected(c.ram_window[63:32])};
        return c;
    endfunction

    function automatic logic [31:0] window_pick(input logic [63:0] win);
        logic [31:0] size;
        logic [31:0] off;
        size = win[63:32];
        case ($urandom_range(3))
            0: off = '0;
            1: off = size - 32'd1;
            default: off = (size == '0) ? 32'($urandom_range(255)) :
                           32'(64'($urandom) % 64'(size));
        endcase
        return win[31:0] + off;
    endfunction

    // Most accesses aim at a window of the current map so that deep cases are reached.
    function automatic t_req random_access(input t_cfg c);
        t_req r;
        r.req_type = 1'($urandom_range(1));
        r.access_size = 2'($urandom_range(3));
        r.supervisor = 1'($urandom_range(1));
        r.write_data = $urandom;
        case ($urandom_range(9))
            0, 1: r.address = window_pick(c.rom_window);
            2, 3: r.address = window_pick(c.sed_window);
            4: r.address = window_pick(c.usb_window);
            5, 6: r.address = window_pick(c.ram_window);
            7: r.address = {REG_BASE[31:BANK_SHIFT], 14'($urandom)};
            8: r.address = {8'($urandom), MIRROR_PATTERN[23:BANK_SHIFT], 14'($urandom)};
            default: r.address = $urandom;
        endcase
        return r;
    endfunction

    task automatic send_access(input t_req r, input logic known, input t_rsp known_rsp);
        while ($urandom_range(99) < sender_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, r.write_data, r.supervisor, r.access_size, r.address};
        s_axis_tuser <= r.req_type;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        decodes_in_flight.push_back(known ? known_rsp : decode_access(r, chip_map));
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (decodes_in_flight.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
    endtask

    task automatic load_config(input t_cfg c);
        reg_write(IDX_ROM_WINDOW, c.rom_window);
        reg_write(IDX_ROM_ATTR, 64'(c.rom_attr));
        reg_write(IDX_SED_WINDOW, c.sed_window);
        reg_write(IDX_SED_ATTR, 64'(c.sed_attr));
        reg_write(IDX_USB_WINDOW, c.usb_window);
        reg_write(IDX_USB_ATTR, 64'(c.usb_attr));
        reg_write(IDX_RAM_WINDOW, c.ram_window);
        reg_write(IDX_RAM_ATTR, 64'(c.ram_attr));
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        chip_map = c;
    endtask

    always @(posedge i_clk) begin
        t_rsp seen;
        t_rsp want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen.target = m_axis_tuser;
            seen.local_offset = m_axis_tdata[31:0];
            seen.data_out = m_axis_tdata[63:32];
            seen.size_out = m_axis_tdata[65:64];
            seen.forward_access = m_axis_tdata[66];
            seen.read_zero = m_axis_tdata[67];
            seen.privilege_fault = m_axis_tdata[68];
            seen.write_protect_fault = m_axis_tdata[69];
            seen.bus_error = m_axis_tdata[70];
            if (decodes_in_flight.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected decode result: target %0d offset %h",
                             seen.target, seen.local_offset);
            end else begin
                want = decodes_in_flight.pop_front();
                if (seen.target !== want.target || seen.local_offset !== want.local_offset ||
                    seen.data_out !== want.data_out || seen.size_out !== want.size_out ||
                    seen.forward_access !== want.forward_access ||
                    seen.read_zero !== want.read_zero ||
                    seen.privilege_fault !== want.privilege_fault ||
                    seen.write_protect_fault !== want.write_protect_fault ||
                    seen.bus_error !== want.bus_error) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"decode mismatch (expected/actual): target %0d/%0d ",
                                  "offset %h/%h data %h/%h size %0d/%0d ",
                                  "fwd,rz,priv,wp,berr %b/%b"},
                                 want.target, seen.target,
                                 want.local_offset, seen.local_offset,
                                 want.data_out, seen.data_out,
                                 want.size_out, seen.size_out,
                                 {want.forward_access, want.read_zero, want.privilege_fault,
                                  want.write_protect_fault, want.bus_error},
                                 {seen.forward_access, seen.read_zero, seen.privilege_fault,
                                  seen.write_protect_fault, seen.bus_error});
                end
            end
        end
        // A long hold-off lets the pipeline fill so that the input side stalls.
        if (stall_request) begin
            stall_left = STALL_STRETCH;
            stall_request = 1'b0;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    initial begin
        t_stim_row rows[$];
        t_cfg      map_a;
        t_cfg      map_b;
        t_cfg      phase_map;

        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= '0;
        m_axis_tready <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        chip_map = '0;
        chip_map.rom_attr = ROM_ATTR_RESET;
        sender_gap_pct = 35;
        receiver_stall_pct = 85;

        map_a = '0;
        map_a.rom_window = {32'h0010_0000, 32'h0000_0000};
        map_a.rom_attr = 38'h0000_1000;
        map_a.rom_attr[ATTR_MIRROR] = 1'b1;
        map_a.rom_attr[ATTR_ENABLE] = 1'b1;
        map_a.rom_attr[ATTR_SUPER] = 1'b1;
        map_a.sed_window = {32'h0004_0000, 32'h1000_0000};
        map_a.sed_attr = 38'h0000_0100;
        map_a.sed_attr[ATTR_ATTACH] = 1'b1;
        map_a.sed_attr[ATTR_ENABLE] = 1'b1;
        map_a.sed_attr[ATTR_RO_PROT] = 1'b1;
        map_a.usb_window = {32'h0000_4000, 32'h2000_0000};
        map_a.usb_attr[ATTR_ENABLE] = 1'b1;
        // RAM window runs past the top of the address space.
        map_a.ram_window = {32'h8000_0000, 32'hC000_0000};
        map_a.ram_attr = 36'h0010_0000;
        map_a.ram_attr[ATTR_ENABLE] = 1'b1;
        map_a.ram_attr[ATTR_SUPER] = 1'b1;

        // Power save on the display, an empty USB window and a RAM size that is
        // not a power of two.
        map_b = map_a;
        map_b.sed_attr[ATTR_PSAVE] = 1'b1;
        map_b.sed_attr[ATTR_RO_PROT] = 1'b0;
        map_b.usb_window = {32'h0000_0000, 32'h2000_0000};
        map_b.ram_window = {32'h0000_6000, 32'hC000_0000};

        // After reset the ROM answers everywhere below the register block.
        rows.push_back('{ROW_KNOWN, '0, mk_req(REQ_READ, 32'h0000_0000, SZ_BYTE, 1'b0, 32'h0),
                         mk_rsp(TGT_ROM, 32'h0, 32'h0, SZ_BYTE, 5'b10000)});
        rows.push_back('{ROW_KNOWN, '0, mk_req(REQ_READ, 32'hFFFF_FFFF, SZ_LONG, 1'b1, 32'h0),
                         mk_rsp(TGT_REGS, 32'hFFF, 32'h0, SZ_LONG, 5'b10000)});
        rows.push_back('{ROW_KNOWN, '0,
                         mk_req(REQ_WRITE, 32'hFFFF_F000, SZ_LONG_PRE, 1'b1, 32'h1234_5678),
                         mk_rsp(TGT_REGS, 32'h0, 32'h5678_1234, SZ_LONG, 5'b10000)});
        rows.push_back('{ROW_KNOWN, '0,
                         mk_req(REQ_WRITE, 32'h7FFF_FFFF, SZ_WORD, 1'b0, 32'hFFFF_FFFF),
                         mk_rsp(TGT_ROM, 32'h7FFF_FFFF, 32'hFFFF_FFFF, SZ_WORD, 5'b00000)});
        rows.push_back('{ROW_KNOWN, '0,
                         mk_req(REQ_READ, 32'hFFFF_BFFF, SZ_LONG_PRE, 1'b1, 32'hAAAA_5555),
                         mk_rsp(TGT_ROM, 32'hFFFF_BFFF, 32'h0, SZ_LONG, 5'b10000)});
        rows.push_back('{ROW_KNOWN, '0, mk_req(REQ_WRITE, 32'hFFFF_C000, SZ_BYTE, 1'b0, 32'h0),
                         mk_rsp(TGT_REGS, 32'h0, 32'h0, SZ_BYTE, 5'b10000)});
        rows.push_back('{ROW_CONFIG, map_a, '0, '0});
        rows.push_back('{ROW_PREDICT, '0, mk_req(REQ_READ, 32'h0000_0800, SZ_WORD, 1'b0, 32'h0),
                         '0});
        rows.push_back('{ROW_PREDICT, '0, mk_req(REQ_READ, 32'h0000_2000, SZ_LONG, 1'b0, 32'h0),
                         '0});
        rows.push_back('{ROW_PREDICT, '0, mk_req(REQ_READ, 32'h12FF_F004, SZ_LONG, 1'b0, 32'h0),
                         '0});
        rows.push_back('{ROW_PREDICT, '0,
                         mk_req(REQ_WRITE, 32'h1000_0050, SZ_WORD, 1'b0, 32'h0000_BEEF), '0});
        rows.push_back('{ROW_PREDICT, '0,
                         mk_req(REQ_WRITE, 32'h1000_0200, SZ_BYTE, 1'b1, 32'h0000_00A5), '0});
        rows.push_back('{ROW_PREDICT, '0, mk_req(REQ_READ, 32'h1002_0010, SZ_LONG, 1'b1, 32'h0),
                         '0});
        rows.push_back('{ROW_PREDICT, '0, mk_req(REQ_READ, 32'h2000_0000, SZ_WORD, 1'b1, 32'h0),
                         '0});
        rows.push_back('{ROW_PREDICT, '0,
                         mk_req(REQ_WRITE, 32'h2000_1234, SZ_LONG, 1'b1, 32'h0F0F_F0F0), '0});
        rows.push_back('{ROW_PREDICT, '0, mk_req(REQ_READ, 32'hFFFF_0000, SZ_BYTE, 1'b0, 32'h0),
                         '0});
        rows.push_back('{ROW_PREDICT, '0,
                         mk_req(REQ_WRITE, 32'hC000_0004, SZ_LONG_PRE, 1'b0, 32'hCAFE_0001), '0});
        rows.push_back('{ROW_KNOWN, '0, mk_req(REQ_READ, 32'h5000_0000, SZ_BYTE, 1'b0, 32'h0),
                         mk_rsp(TGT_NONE, 32'h0, 32'h0, SZ_BYTE, 5'b01001)});
        rows.push_back('{ROW_KNOWN, '0,
                         mk_req(REQ_WRITE, 32'h5000_0000, SZ_LONG_PRE, 1'b1, 32'hDEAD_BEEF),
                         mk_rsp(TGT_NONE, 32'h0, 32'hBEEF_DEAD, SZ_LONG, 5'b00001)});
        rows.push_back('{ROW_CONFIG, map_b, '0, '0});
        rows.push_back('{ROW_PREDICT, '0, mk_req(REQ_READ, 32'h1000_0010, SZ_WORD, 1'b1, 32'h0),
                         '0});
        rows.push_back('{ROW_PREDICT, '0,
                         mk_req(REQ_WRITE, 32'h1002_0000, SZ_WORD, 1'b1, 32'h0000_1234), '0});
        rows.push_back('{ROW_PREDICT, '0, mk_req(REQ_READ, 32'h2000_0000, SZ_LONG, 1'b1, 32'h0),
                         '0});
        rows.push_back('{ROW_PREDICT, '0, mk_req(REQ_READ, 32'hC000_5004, SZ_LONG, 1'b1, 32'h0),
                         '0});

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CONFIG) begin
                wait_for_results();
                load_config(rows[i].cfg);
            end else begin
                send_access(rows[i].req, rows[i].kind == ROW_KNOWN, rows[i].rsp);
            end
        end

        // The first two maps are the extremes: everything off, then every bit set.
        for (int p = 0; p < PHASES; p++) begin
            wait_for_results();
            if (p == 0)
                phase_map = '0;
            else if (p == 1)
                phase_map = '1;
            else
                phase_map = random_config();
            load_config(phase_map);
            if (p < 4) begin
                sender_gap_pct = 35;
                receiver_stall_pct = 85;
            end else if (p < 8) begin
                sender_gap_pct = 85;
                receiver_stall_pct = 35;
            end else begin
                sender_gap_pct = 0;
                receiver_stall_pct = 0;
            end
            if (p == 8)
                stall_request = 1'b1;
            repeat (ACCESSES_PER_PHASE)
                send_access(random_access(chip_map), 1'b0, '0);
        end

        wait_for_results();
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- chip_select_address_decoder.f -----
+incdir+design
design/csad_pkg.sv
design/csad_cfg_regs.sv
design/csad_win_match.sv
design/csad_decode.sv
design/chip_select_address_decoder.sv
sim/testbench.sv
